// File: rtl/smavg_pkg.sv
// smavg_pkg: widths, register indexes, clamp helpers and shared types
// for the shifted moving average core; depends on nothing
`timescale 1ns / 1ps

package smavg_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int SUM_W      = 40;
    localparam int RING_AW    = 9;
    localparam int COUNT_W    = 10;
    localparam int PERIOD_W   = 9;
    localparam int SHIFT_W    = 8;
    localparam int CFG_AW     = 1;
    localparam int CFG_DW     = 9;
    localparam int MAX_PERIOD = 256;
    localparam int MAX_SHIFT  = 255;
    localparam int DIV_STEPS  = SUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);

    localparam logic [CFG_AW-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_WINDOW_SHIFT  = 1'b1;

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } smavg_div_stat_t;

    function automatic logic [PERIOD_W-1:0] eff_period(input logic [PERIOD_W-1:0] p);
        logic [PERIOD_W-1:0] r;
        r = p;
        if (p == '0) begin
            r = PERIOD_W'(1);
        end else if (int'(p) > MAX_PERIOD) begin
            r = PERIOD_W'(MAX_PERIOD);
        end
        return r;
    endfunction

    function automatic logic [SHIFT_W-1:0] eff_shift(input logic [SHIFT_W-1:0] s);
        logic [SHIFT_W-1:0] r;
        r = s;
        if (int'(s) > MAX_SHIFT) begin
            r = SHIFT_W'(MAX_SHIFT);
        end
        return r;
    endfunction

    function automatic logic [SUM_W-1:0] widen(input logic [SAMPLE_W-1:0] x);
        return {{(SUM_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
    endfunction

endpackage

// File: rtl/shifted_moving_average_core.sv
// shifted_moving_average_core: top level, sequencer, shared 40-bit adder,
// history ring and divider; depends on smavg_pkg, smavg_ring, smavg_div
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata = sample, s_tuser = series_start
// m_       out  m_tvalid/m_tready  m_tdata = average, m_tuser = average_valid
// cfg_     in   cfg_wen            cfg_addr = register index, cfg_wdata = value
//
// one beat at a time: a beat whose window is complete goes from accept to result
// through write, add, subtract, magnitude, 40 divider steps, capture and output
// load; a beat without a valid window skips the magnitude and divider steps
// the 40-step restoring divider sets the rate
// aresetn is synchronous and active low; the history memory is not cleared
// a result held on m_ does not block the next s_ beat; the sequencer waits
// only if a new result is ready while the previous one is still held

module shifted_moving_average_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    // sample stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [31:0]                      s_tdata,   // [31:0] sample
    input  logic                             s_tuser,   // [0] series_start
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [31:0]                      m_tdata,   // [31:0] average
    output logic                             m_tuser,   // [0] average_valid
    // configuration writes
    input  logic                             cfg_wen,
    input  logic [smavg_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [smavg_pkg::CFG_DW-1:0]     cfg_wdata
);
    import smavg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_ADD,
        S_SUB,
        S_MAG,
        S_DIV,
        S_OUT
    } state_t;

    state_t              state_reg, state_next;
    logic [SAMPLE_W-1:0] sample_reg, sample_next;
    logic                start_reg, start_next;
    logic [RING_AW-1:0]  wp_reg, wp_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  seen_reg, seen_next;
    logic                neg_reg, neg_next;
    logic [SAMPLE_W-1:0] res_reg, res_next;
    logic                resv_reg, resv_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [SAMPLE_W-1:0] m_tdata_reg, m_tdata_next;
    logic                m_tuser_reg, m_tuser_next;

    logic [PERIOD_W-1:0] window_length_reg;
    logic [SHIFT_W-1:0]  window_shift_reg;

    // effective window settings and the span back to the oldest sample
    logic [PERIOD_W-1:0] period;
    logic [SHIFT_W-1:0]  shift;
    logic [COUNT_W-1:0]  span;
    logic [COUNT_W-1:0]  seen_base;

    // shared adder / subtractor
    logic [SUM_W-1:0]    alu_a;
    logic [SUM_W-1:0]    alu_b;
    logic                alu_sub;
    logic [SUM_W-1:0]    alu_out;

    logic                ring_we;
    logic [RING_AW-1:0]  ring_raddr;
    logic [SAMPLE_W-1:0] ring_rdata;

    logic                div_start;
    smavg_div_stat_t     div_stat;
    logic [SUM_W-1:0]    div_q;
    logic [SUM_W-1:0]    q_sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= PERIOD_W'(1);
            window_shift_reg  <= '0;
        end else if (cfg_wen) begin
            case (cfg_addr)
                CFG_WINDOW_LENGTH: window_length_reg <= cfg_wdata;
                CFG_WINDOW_SHIFT:  window_shift_reg  <= cfg_wdata[SHIFT_W-1:0];
                default: ;
            endcase
        end
    end

    assign period  = eff_period(window_length_reg);
    assign shift   = eff_shift(window_shift_reg);
    assign span    = COUNT_W'(shift) + COUNT_W'(period);
    assign alu_out = alu_a + (alu_b ^ {SUM_W{alu_sub}}) + SUM_W'(alu_sub);

    always_comb begin
        state_next    = state_reg;
        sample_next   = sample_reg;
        start_next    = start_reg;
        wp_next       = wp_reg;
        sum_next      = sum_reg;
        seen_next     = seen_reg;
        neg_next      = neg_reg;
        res_next      = res_reg;
        resv_next     = resv_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        alu_a         = sum_reg;
        alu_b         = widen(ring_rdata);
        alu_sub       = 1'b0;
        ring_we       = 1'b0;
        ring_raddr    = wp_reg - RING_AW'(shift);
        div_start     = 1'b0;
        seen_base     = start_reg ? '0 : seen_reg;
        q_sat         = div_q;

        // result taken downstream frees the output register
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    sample_next = s_tdata;
                    start_next  = s_tuser;
                    state_next  = S_WRITE;
                end
            end
            S_WRITE: begin
                // store the sample, count it, fetch the entry entering the window
                ring_we = 1'b1;
                if (start_reg) begin
                    sum_next = '0;
                end
                if (seen_base != {COUNT_W{1'b1}}) begin
                    seen_next = seen_base + COUNT_W'(1);
                end else begin
                    seen_next = seen_base;
                end
                state_next = S_ADD;
            end
            S_ADD: begin
                // zero shift: the entering sample is the one just written
                if (shift == '0) begin
                    alu_b = widen(sample_reg);
                end
                if (seen_reg > COUNT_W'(shift)) begin
                    sum_next = alu_out;
                end
                ring_raddr = wp_reg - span[RING_AW-1:0];
                state_next = S_SUB;
            end
            S_SUB: begin
                // drop the entry leaving the window
                alu_sub = 1'b1;
                if (seen_reg > span) begin
                    sum_next = alu_out;
                end
                wp_next = wp_reg + RING_AW'(1);
                if (seen_reg >= span) begin
                    state_next = S_MAG;
                end else begin
                    res_next   = '0;
                    resv_next  = 1'b0;
                    state_next = S_OUT;
                end
            end
            S_MAG: begin
                // magnitude through the same adder: 0 - sum when negative
                alu_a      = '0;
                alu_b      = sum_reg;
                alu_sub    = sum_reg[SUM_W-1];
                neg_next   = sum_reg[SUM_W-1];
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_stat.done) begin
                    // saturate to the signed 32-bit range
                    if (!neg_reg) begin
                        if (div_q > SUM_W'(32'h7FFF_FFFF)) begin
                            q_sat = SUM_W'(32'h7FFF_FFFF);
                        end
                        res_next = q_sat[SAMPLE_W-1:0];
                    end else begin
                        if (div_q > SUM_W'(32'h8000_0000)) begin
                            q_sat = SUM_W'(32'h8000_0000);
                        end
                        res_next = ~q_sat[SAMPLE_W-1:0] + SAMPLE_W'(1);
                    end
                    resv_next  = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = res_reg;
                    m_tuser_next  = resv_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            wp_reg       <= '0;
            sum_reg      <= '0;
            seen_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wp_reg       <= wp_next;
            sum_reg      <= sum_next;
            seen_reg     <= seen_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        sample_reg  <= sample_next;
        start_reg   <= start_next;
        neg_reg     <= neg_next;
        res_reg     <= res_next;
        resv_reg    <= resv_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    smavg_ring u_ring (
        .aclk    (aclk),
        .wr_en   (ring_we),
        .wr_addr (wp_reg),
        .wr_data (sample_reg),
        .rd_addr (ring_raddr),
        .rd_data (ring_rdata)
    );

    smavg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (alu_out),
        .divisor  (period),
        .stat     (div_stat),
        .quotient (div_q)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTH
    // the divider never runs while a new beat can be taken
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !div_stat.busy)
        else $error("divider busy while accepting a beat");

    // divider completion is seen only by the waiting state
    a_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside the wait state");

    // a result without a full window carries a zero average
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("invalid result with nonzero average");

    // each accepted beat advances the ring write slot by one
    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SUB) |=> (wp_reg == $past(wp_reg) + RING_AW'(1)))
        else $error("write slot did not advance");
`endif

endmodule

// File: rtl/smavg_ring.sv
// smavg_ring: sample history memory, one write and one registered read port
// depends on smavg_pkg
`timescale 1ns / 1ps

module smavg_ring (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [smavg_pkg::RING_AW-1:0]  wr_addr,
    input  logic [smavg_pkg::SAMPLE_W-1:0] wr_data,
    input  logic [smavg_pkg::RING_AW-1:0]  rd_addr,
    output logic [smavg_pkg::SAMPLE_W-1:0] rd_data
);
    import smavg_pkg::*;

    logic [SAMPLE_W-1:0] mem [2**RING_AW];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/smavg_div.sv
// smavg_div: restoring divider, one quotient bit per cycle
// depends on smavg_pkg
`timescale 1ns / 1ps

module smavg_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [smavg_pkg::SUM_W-1:0]      dividend,
    input  logic [smavg_pkg::PERIOD_W-1:0]   divisor,
    output smavg_pkg::smavg_div_stat_t       stat,
    output logic [smavg_pkg::SUM_W-1:0]      quotient
);
    import smavg_pkg::*;

    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [SUM_W-1:0]     dq_reg, dq_next;
    logic [PERIOD_W-1:0]  rem_reg, rem_next;
    logic [PERIOD_W-1:0]  dvs_reg, dvs_next;
    logic [PERIOD_W:0]    rem_sh;
    logic [PERIOD_W:0]    rem_sub;
    logic                 ge;

    always_comb begin
        rem_sh    = {rem_reg, dq_reg[SUM_W-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        ge        = rem_sh >= {1'b0, dvs_reg};
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
            dq_next   = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so it fits back in PERIOD_W bits
            rem_next = ge ? rem_sub[PERIOD_W-1:0] : rem_sh[PERIOD_W-1:0];
            dq_next  = {dq_reg[SUM_W-2:0], ge};
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dq_reg;

endmodule

// File: verif/shifted_moving_average_core_tb.sv
// shifted_moving_average_core_tb: self-checking bench for the shifted moving average core,
// directed table then random series, results checked against typed rows or a window model
// depends on smavg_pkg and shifted_moving_average_core
`timescale 1ns / 1ps

module shifted_moving_average_core_tb;

    import smavg_pkg::*;

    localparam int SETTLE_CYCLES = 8;    // margin after the last result before a register write
    localparam int TAIL_CYCLES   = 60;   // longer than one full beat through the divider
    localparam int RANDOM_BEATS  = 150;
    localparam int EXTREME_BEATS = 280;  // enough to get past the widest window and its shift

    // one result beat as seen on m_
    typedef struct packed {
        logic [SAMPLE_W-1:0] average;
        logic                average_valid;
    } mean_beat_t;

    // rows of the directed table
    typedef enum logic [1:0] {
        ROW_WINDOW,          // register write, taken only when the core is idle
        ROW_BEAT_TYPED,      // sample with its result written into the row
        ROW_BEAT_PREDICTED   // sample checked against the window model
    } row_kind_t;

    typedef struct {
        row_kind_t           kind;
        logic [PERIOD_W-1:0] length;
        logic [SHIFT_W-1:0]  shift;
        logic [SAMPLE_W-1:0] sample;
        logic                restart;
        mean_beat_t          mean;
    } stim_row_t;

    // ---------------------------------------------------------------------
    // clock, reset and core
    // ---------------------------------------------------------------------
    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [31:0]          s_tdata   = '0;     // [31:0] sample
    logic                 s_tuser   = 1'b0;   // [0] series_start
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;            // [31:0] average
    logic                 m_tuser;            // [0] average_valid
    logic                 cfg_wen   = 1'b0;
    logic [CFG_AW-1:0]    cfg_addr  = '0;
    logic [CFG_DW-1:0]    cfg_wdata = '0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    shifted_moving_average_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wen   (cfg_wen),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // ---------------------------------------------------------------------
    // window model: own copy of the registers and the running state
    // ---------------------------------------------------------------------
    logic [PERIOD_W-1:0] len_reg   = PERIOD_W'(1);
    logic [SHIFT_W-1:0]  shift_reg = '0;
    logic [SAMPLE_W-1:0] history [0:(1<<RING_AW)-1];
    logic [RING_AW-1:0]  wr_ptr    = '0;
    logic [SUM_W-1:0]    run_sum   = '0;
    logic [COUNT_W-1:0]  seen_count = '0;

    mean_beat_t pending_means [$];   // expected results, oldest first
    int         mismatches = 0;
    logic       quiet_send = 1'b0;   // sender never idles while set
    logic       quiet_recv = 1'b0;   // receiver never stalls while set

    // zero length counts as one, anything past MAX_PERIOD counts as MAX_PERIOD
    function automatic int period_in_use(input logic [PERIOD_W-1:0] length);
        if (length == '0) begin
            return 1;
        end
        if (int'(length) > MAX_PERIOD) begin
            return MAX_PERIOD;
        end
        return int'(length);
    endfunction

    // takes one sample into the window and returns the mean it produces
    function automatic mean_beat_t advance_window(input logic [SAMPLE_W-1:0] smp,
                                                  input logic restart);
        int               period;
        int               lag;
        logic [SUM_W-1:0] mag;
        logic [SUM_W-1:0] quot;
        mean_beat_t       res;
        period = period_in_use(len_reg);
        lag    = int'(shift_reg);
        if (restart) begin
            run_sum    = '0;
            seen_count = '0;
        end
        history[wr_ptr] = smp;
        if (seen_count != '1) begin
            seen_count = seen_count + 1'b1;
        end
        // newest sample entering the window, and the one falling out of it
        if (int'(seen_count) > lag) begin
            run_sum = run_sum + SUM_W'($signed(history[RING_AW'(wr_ptr - RING_AW'(lag))]));
        end
        if (int'(seen_count) > lag + period) begin
            run_sum = run_sum
                      - SUM_W'($signed(history[RING_AW'(wr_ptr - RING_AW'(lag + period))]));
        end
        wr_ptr = wr_ptr + 1'b1;
        res = '0;
        if (int'(seen_count) >= lag + period) begin
            // divide the magnitude, truncate toward zero, saturate to 32 bits
            mag  = run_sum[SUM_W-1] ? SUM_W'(-run_sum) : run_sum;
            quot = mag / SUM_W'(period);
            if (!run_sum[SUM_W-1]) begin
                res.average = (quot > SUM_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : quot[31:0];
            end else begin
                if (quot > SUM_W'(32'h8000_0000)) begin
                    quot = SUM_W'(32'h8000_0000);
                end
                res.average = 32'h0 - quot[31:0];
            end
            res.average_valid = 1'b1;
        end
        return res;
    endfunction

    // ---------------------------------------------------------------------
    // sender side helpers
    // ---------------------------------------------------------------------
    // one sample beat, with a random gap in front; the expected mean is queued at accept
    task automatic send_sample(input logic [SAMPLE_W-1:0] smp, input logic restart,
                               input logic typed, input mean_beat_t typed_mean);
        int         gap;
        mean_beat_t predicted;
        gap = quiet_send ? 0 : $urandom_range(0, 12);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tuser  <= restart;
        do @(posedge aclk); while (!s_tready);
        predicted = advance_window(smp, restart);
        pending_means.push_back(typed ? typed_mean : predicted);
    endtask

    // hold off until every queued mean has come back, then let the core settle
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_means.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // both registers, one write per cycle; the model follows at the same edge
    task automatic set_window(input logic [PERIOD_W-1:0] length,
                              input logic [SHIFT_W-1:0] shift);
        cfg_wen   <= 1'b1;
        cfg_addr  <= CFG_WINDOW_LENGTH;
        cfg_wdata <= CFG_DW'(length);
        @(posedge aclk);
        len_reg   = length;
        cfg_addr  <= CFG_WINDOW_SHIFT;
        cfg_wdata <= CFG_DW'(shift);
        @(posedge aclk);
        shift_reg = shift;
        cfg_wen   <= 1'b0;
    endtask

    // mix of full-range values, the extremes, small values and large same-sign values
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 19))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4, 5, 6, 7: begin
                return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
            end
            8, 9:    return 32'h7000_0000 | ($urandom & 32'h0FFF_FFFF);
            10:      return 32'h8000_0000 | ($urandom & 32'h0FFF_FFFF);
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_row_t window_row(input logic [PERIOD_W-1:0] length,
                                             input logic [SHIFT_W-1:0] shift);
        stim_row_t r;
        r        = '{kind: ROW_WINDOW, default: '0};
        r.length = length;
        r.shift  = shift;
        return r;
    endfunction

    function automatic stim_row_t beat_row(input row_kind_t kind, input logic [31:0] smp,
                                           input logic restart, input logic [31:0] avg,
                                           input logic valid);
        stim_row_t r;
        r         = '{kind: kind, default: '0};
        r.sample  = smp;
        r.restart = restart;
        r.mean    = '{average: avg, average_valid: valid};
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        stim_row_t  directed_rows [$];
        int         random_beats;
        int         beats;
        int         need;
        logic       carry;
        logic [PERIOD_W-1:0] length;
        logic [SHIFT_W-1:0]  shift;

        // reset defaults: window of one, no shift, so each mean is the sample itself
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 1'b1));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h8000_0000, 1'b0, 32'h8000_0000, 1'b1));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h0000_0000, 1'b0, 32'h0000_0000, 1'b1));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 1'b1));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h0000_0001, 1'b0, 32'h0000_0001, 1'b1));
        // zero length behaves as a window of one
        directed_rows.push_back(window_row(9'd0, 8'd0));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h1234_5678, 1'b1, 32'h1234_5678, 1'b1));
        // window of two: first mean not ready, then truncation toward zero on negatives
        directed_rows.push_back(window_row(9'd2, 8'd0));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_PREDICTED, 32'hFFFF_FFFE, 1'b0, '0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_PREDICTED, 32'h7FFF_FFFF, 1'b0, '0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_PREDICTED, 32'h7FFF_FFFF, 1'b0, '0, 1'b0));
        // shifted window: not valid until length plus shift samples
        directed_rows.push_back(window_row(9'd3, 8'd2));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h0003_0000, 1'b1, 32'h0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h0006_0000, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h0009_0000, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h000C_0000, 1'b0, 32'h0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_PREDICTED, 32'h000F_0000, 1'b0, '0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_PREDICTED, 32'h8000_0000, 1'b0, '0, 1'b0));
        // series start in the middle clears sum and count
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h0001_0000, 1'b1, 32'h0, 1'b0));
        // length past the limit clamps; far from valid here
        directed_rows.push_back(window_row(9'd511, 8'd255));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h8000_0000, 1'b1, 32'h0, 1'b0));
        directed_rows.push_back(beat_row(ROW_BEAT_TYPED, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0));
        // registers changed inside a series: sum carries on unrecomputed
        directed_rows.push_back(window_row(9'd1, 8'd0));
        directed_rows.push_back(beat_row(ROW_BEAT_PREDICTED, 32'hFFFF_FFFF, 1'b0, '0, 1'b0));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_WINDOW: begin
                    wait_idle();
                    set_window(directed_rows[i].length, directed_rows[i].shift);
                end
                ROW_BEAT_TYPED: begin
                    send_sample(directed_rows[i].sample, directed_rows[i].restart, 1'b1,
                                directed_rows[i].mean);
                end
                default: begin
                    send_sample(directed_rows[i].sample, directed_rows[i].restart, 1'b0, '0);
                end
            endcase
        end

        // widest window with a short shift, long enough to reach valid means
        wait_idle();
        set_window(9'd256, 8'd4);
        for (int i = 0; i < EXTREME_BEATS; i++) begin
            send_sample(rand_sample(), i == 0, 1'b0, '0);
        end

        // random phases; each one starts from an idle core with new registers
        random_beats = 0;
        while (random_beats < RANDOM_BEATS) begin
            wait_idle();
            case ($urandom_range(0, 19))
                0, 1:        length = 9'd0;
                2, 3:        length = 9'd1;
                4:           length = 9'd256;
                5:           length = 9'd511;
                6, 7, 8:     length = PERIOD_W'($urandom_range(9, 64));
                9, 10:       length = PERIOD_W'($urandom_range(0, 511));
                default:     length = PERIOD_W'($urandom_range(1, 8));
            endcase
            case ($urandom_range(0, 19))
                0, 1:        shift = 8'd0;
                2:           shift = 8'd255;
                3, 4, 5, 6:  shift = SHIFT_W'($urandom_range(0, 255));
                default:     shift = SHIFT_W'($urandom_range(0, 4));
            endcase
            carry      = ($urandom_range(0, 3) == 0);   // keep the running series
            quiet_send = ($urandom_range(0, 4) == 0);
            quiet_recv = ($urandom_range(0, 4) == 0);
            set_window(length, shift);
            need  = period_in_use(length) + int'(shift);
            beats = (need <= 100) ? need + $urandom_range(1, 60) : $urandom_range(20, 80);
            for (int i = 0; i < beats && random_beats < RANDOM_BEATS; i++) begin
                send_sample(rand_sample(), (i == 0 && !carry) || $urandom_range(0, 49) == 0,
                            1'b0, '0);
                random_beats++;
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // ---------------------------------------------------------------------
    // receiver: random stalls per result, checks every accepted beat
    // ---------------------------------------------------------------------
    int recv_wait = 0;

    always @(posedge aclk) begin : result_check
        mean_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_means.size() == 0) begin
                $display("%0t: result beat with nothing expected, got average %h valid %b",
                         $time, m_tdata, m_tuser);
                mismatches++;
            end else begin
                want = pending_means.pop_front();
                if (m_tdata !== want.average) begin
                    $display("%0t: average mismatch, expected %h, got %h",
                             $time, want.average, m_tdata);
                    mismatches++;
                end
                if (m_tuser !== want.average_valid) begin
                    $display("%0t: average_valid mismatch, expected %b, got %b",
                             $time, want.average_valid, m_tuser);
                    mismatches++;
                end
            end
            recv_wait = quiet_recv ? 0 : $urandom_range(0, 12);
        end else if (recv_wait != 0) begin
            recv_wait = recv_wait - 1;
        end
        m_tready <= aresetn && (recv_wait == 0);
    end

    // hang guard, far past the slowest legal run
    initial begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
rtl/smavg_pkg.sv
rtl/smavg_ring.sv
rtl/smavg_div.sv
rtl/shifted_moving_average_core.sv
verif/shifted_moving_average_core_tb.sv
